FILE: design/i2cms_pkg.sv
// Package for the I2C master byte sequencer.
// Holds the command codes, packing widths and the controller/datapath command
// and status structs. No dependencies.
package i2cms_pkg;

   // Command codes carried in the operation field
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam int BYTE_BITS     = 8;
   localparam int REQ_DATA_BITS = 24;  // 2 + 8 + 8 bits, padded to whole bytes
   localparam int RSP_DATA_BITS = 16;  // 1 + 1 + 1 + 8 bits, padded to whole bytes

   // Controller -> datapath command, one per cycle
   typedef struct packed {
      logic load;       // capture the byte for a new command
      logic rotate;     // rotate the byte left by one bit
      logic emit;       // write one slot into the output register
      logic scl;        // clock level of the slot
      logic sda_data;   // SDA follows the byte's MSB instead of sda_const
      logic sda_const;  // fixed SDA level of the slot
      logic drv;        // master drives SDA
      logic put_rd;     // place the assembled byte on this slot
      logic last;       // final slot of the command
   } dp_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic slot_free;  // output register can take a slot this cycle
   } dp_status_type;

endpackage

FILE: design/i2cms_ctrl.sv
// Controller of the I2C master byte sequencer.
// Walks the slots of start, stop, write and read commands with a bit counter
// and a phase counter. Depends on i2cms_pkg.
module i2cms_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  logic [1:0]               cmd_op,
   output logic                     cmd_ready,
   input  i2cms_pkg::dp_status_type dp_status,
   output i2cms_pkg::dp_cmd_type    dp_cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_STOP  = 3'd2;
   localparam logic [2:0] ST_BITS  = 3'd3;
   localparam logic [2:0] ST_ACK   = 3'd4;

   localparam logic [1:0] PH_LAST = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [1:0] phase_ff, phase_in;
   logic       is_read_ff, is_read_in;
   logic       adv;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign adv       = dp_status.slot_free;

   // Next state and slot pattern
   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      phase_in   = phase_ff;
      is_read_in = is_read_ff;
      dp_cmd     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               dp_cmd.load = 1'b1;
               bit_cnt_in  = '0;
               phase_in    = '0;
               is_read_in  = (cmd_op == i2cms_pkg::OP_READ);
               unique case (cmd_op)
                  i2cms_pkg::OP_START: state_in = ST_START;
                  i2cms_pkg::OP_STOP:  state_in = ST_STOP;
                  i2cms_pkg::OP_WRITE: state_in = ST_BITS;
                  i2cms_pkg::OP_READ:  state_in = ST_BITS;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_START, ST_STOP: begin
            // SDA falls (start) or rises (stop) while SCL is high
            dp_cmd.emit      = adv;
            dp_cmd.scl       = 1'b1;
            dp_cmd.drv       = 1'b1;
            dp_cmd.sda_const = (phase_ff == 2'd0) ^ (state_ff == ST_STOP);
            dp_cmd.last      = (phase_ff != 2'd0);
            if (adv) begin
               if (phase_ff != 2'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = 2'd1;
               end
            end
         end
         ST_BITS: begin
            dp_cmd.emit      = adv;
            dp_cmd.sda_const = 1'b1;
            if (is_read_ff) begin
               // released SDA; SCL high, high, low
               dp_cmd.scl = (phase_ff != PH_LAST);
            end else begin
               dp_cmd.scl      = (phase_ff == 2'd1);
               dp_cmd.sda_data = 1'b1;
               dp_cmd.drv      = 1'b1;
            end
            if (adv) begin
               if (phase_ff == PH_LAST) begin
                  dp_cmd.rotate = 1'b1;
                  phase_in      = '0;
                  bit_cnt_in    = bit_cnt_ff + 3'd1;
                  if (bit_cnt_ff == 3'(i2cms_pkg::BYTE_BITS - 1)) begin
                     state_in = ST_ACK;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_ACK: begin
            // released acknowledge clock, never sampled
            dp_cmd.emit      = adv;
            dp_cmd.scl       = (phase_ff == 2'd1);
            dp_cmd.sda_const = 1'b1;
            dp_cmd.last      = (phase_ff == PH_LAST);
            dp_cmd.put_rd    = (phase_ff == PH_LAST) && is_read_ff;
            if (adv) begin
               if (phase_ff == PH_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         phase_ff   <= '0;
         is_read_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         phase_ff   <= phase_in;
         is_read_ff <= is_read_in;
      end
   end

endmodule

FILE: design/i2cms_datapath.sv
// Datapath of the I2C master byte sequencer.
// Byte shift register (rotating, so a read returns the sampled byte) and the
// registered output slot with its valid flag. Depends on i2cms_pkg.
module i2cms_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  i2cms_pkg::dp_cmd_type    dp_cmd,
   output i2cms_pkg::dp_status_type dp_status,
   input  logic [1:0]               load_op,
   input  logic [7:0]               load_write_data,
   input  logic [7:0]               load_target_bits,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_scl,
   output logic                     out_sda_value,
   output logic                     out_sda_driven,
   output logic [7:0]               out_read_data,
   output logic                     out_last
);

   logic [7:0] shift_ff, shift_in;
   logic       valid_ff, valid_in;
   logic       scl_ff, sda_ff, drv_ff, last_ff;
   logic [7:0] rd_ff;

   assign dp_status.slot_free = !valid_ff || out_ready;

   // Byte register: load on command, rotate after each bit clock
   always_comb begin
      shift_in = shift_ff;
      if (dp_cmd.load) begin
         shift_in = (load_op == i2cms_pkg::OP_READ) ? load_target_bits : load_write_data;
      end else if (dp_cmd.rotate) begin
         shift_in = {shift_ff[6:0], shift_ff[7]};
      end
   end

   // Output valid flag
   always_comb begin
      valid_in = valid_ff;
      if (dp_cmd.emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         shift_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         shift_ff <= shift_in;
      end
   end

   // Slot payload; reset value is SCL high, SDA high driven
   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff  <= 1'b1;
         sda_ff  <= 1'b1;
         drv_ff  <= 1'b1;
         rd_ff   <= '0;
         last_ff <= 1'b0;
      end else if (dp_cmd.emit) begin
         scl_ff  <= dp_cmd.scl;
         sda_ff  <= dp_cmd.sda_data ? shift_ff[7] : dp_cmd.sda_const;
         drv_ff  <= dp_cmd.drv;
         rd_ff   <= dp_cmd.put_rd ? shift_ff : 8'd0;
         last_ff <= dp_cmd.last;
      end
   end

   assign out_valid      = valid_ff;
   assign out_scl        = scl_ff;
   assign out_sda_value  = sda_ff;
   assign out_sda_driven = drv_ff;
   assign out_read_data  = rd_ff;
   assign out_last       = last_ff;

endmodule

FILE: design/i2c_master_byte_sequencer.sv
// I2C master byte sequencer, top level: one command in, a run of pin slots out.
// After a command is accepted its slots enter the output register one per cycle,
// unless the output register is full and rsp_tready is low. Start/stop: 2 slots,
// write/read: 27 slots; the next command is taken only once the controller is
// back in idle, which it reaches as the last slot enters the output register.
// Reset: synchronous, active high; idle, no slot pending, pins SCL high and SDA high driven.
module i2c_master_byte_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] operation, [9:2] write_data, [17:10] target_bits, [23:18] zero
   input  logic [i2cms_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl_level, [1] sda_value, [2] sda_driven, [10:3] read_data, [15:11] zero
   output logic [i2cms_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                  rsp_tlast
);

   i2cms_pkg::dp_cmd_type    dp_cmd;
   i2cms_pkg::dp_status_type dp_status;
   logic                     scl, sda, drv;
   logic [7:0]               rd;

   i2cms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_op    (req_tdata[1:0]),
      .cmd_ready (req_tready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   i2cms_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .load_op          (req_tdata[1:0]),
      .load_write_data  (req_tdata[9:2]),
      .load_target_bits (req_tdata[17:10]),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_scl          (scl),
      .out_sda_value    (sda),
      .out_sda_driven   (drv),
      .out_read_data    (rd),
      .out_last         (rsp_tlast)
   );

   // Pack the slot fields, lowest first
   assign rsp_tdata = {5'd0, rd, drv, sda, scl};

endmodule

FILE: tb/sv/i2c_master_byte_sequencer_checker.sv
`timescale 1ns / 100ps
// Checker for the I2C master byte sequencer: watches both stream channels, predicts
// the pin slots of every accepted command and compares them with the returned slots.
// Depends on i2cms_pkg for the command codes and the channel widths.
module i2c_master_byte_sequencer_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   // [1:0] operation, [9:2] write_data, [17:10] target_bits, [23:18] zero
   input  logic [i2cms_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] scl_level, [1] sda_value, [2] sda_driven, [10:3] read_data, [15:11] zero
   input  logic [i2cms_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                  rsp_tlast,
   output int                                    fail_count,
   output int                                    slots_pending
);

   // One slot of pin state as the block reports it
   typedef struct packed {
      bit         scl;
      bit         sda;
      bit         drv;
      bit [7:0]   rd;
      bit         last;
   } pin_slot_type;

   pin_slot_type slot_queue[$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   task automatic push_slot(bit scl, bit sda, bit drv, bit [7:0] rd, bit last);
      pin_slot_type s;
      s.scl  = scl;
      s.sda  = sda;
      s.drv  = drv;
      s.rd   = rd;
      s.last = last;
      slot_queue.push_back(s);
   endtask

   // Pin sequence of one command; released SDA reads back as 1
   task automatic predict_pin_slots(logic [1:0] op, logic [7:0] wr_byte, logic [7:0] tgt);
      bit [7:0] shreg;
      shreg = '0;
      case (op)
         i2cms_pkg::OP_START: begin
            push_slot(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
            push_slot(1'b1, 1'b0, 1'b1, 8'h00, 1'b1);
         end
         i2cms_pkg::OP_STOP: begin
            push_slot(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
            push_slot(1'b1, 1'b1, 1'b1, 8'h00, 1'b1);
         end
         i2cms_pkg::OP_WRITE: begin
            shreg = wr_byte;
            // low, high, low per bit, data MSB first
            for (int i = 0; i < i2cms_pkg::BYTE_BITS; i++) begin
               for (int ph = 0; ph < 3; ph++)
                  push_slot(ph == 1, shreg[7], 1'b1, 8'h00, 1'b0);
               shreg = shreg << 1;
            end
            push_slot(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            push_slot(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
            push_slot(1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
         end
         default: begin
            // read: high, high, low per bit, sampled in the first high slot
            for (int i = 0; i < i2cms_pkg::BYTE_BITS; i++) begin
               push_slot(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
               shreg = {shreg[6:0], tgt[7 - i]};
               push_slot(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
               push_slot(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            end
            // NACK clock, byte returned on the last slot
            push_slot(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
            push_slot(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
            push_slot(1'b0, 1'b1, 1'b0, shreg, 1'b1);
         end
      endcase
   endtask

   // Predict on accepted commands, compare on accepted slots
   always @(posedge clock) begin : watch
      pin_slot_type want;
      pin_slot_type got;
      bit           pad_bad;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_pin_slots(req_tdata[1:0], req_tdata[9:2], req_tdata[17:10]);
         if (rsp_tvalid && rsp_tready) begin
            got.scl  = rsp_tdata[0];
            got.sda  = rsp_tdata[1];
            got.drv  = rsp_tdata[2];
            got.rd   = rsp_tdata[10:3];
            got.last = rsp_tlast;
            pad_bad  = (rsp_tdata[15:11] != '0);
            if (slot_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected slot scl=%0b sda=%0b drv=%0b rd=%02h last=%0b",
                           $realtime, got.scl, got.sda, got.drv, got.rd, got.last);
            end else begin
               want = slot_queue.pop_front();
               if (got.scl != want.scl || got.sda != want.sda || got.drv != want.drv ||
                   got.rd != want.rd || got.last != want.last || pad_bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: slot mismatch: expected scl=%0b sda=%0b drv=%0b ",
                               "rd=%02h last=%0b, got scl=%0b sda=%0b drv=%0b rd=%02h ",
                               "last=%0b pad=%02h"},
                              $realtime, want.scl, want.sda, want.drv, want.rd, want.last,
                              got.scl, got.sda, got.drv, got.rd, got.last,
                              rsp_tdata[15:11]);
               end
            end
         end
         slots_pending <= slot_queue.size();
      end else begin
         slots_pending <= 0;
      end
   end

endmodule

FILE: tb/sv/i2c_master_byte_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the I2C master byte sequencer: drives commands with random
// gaps and back-pressure, and gives the verdict from the checker's failure count and pending slots.
// Depends on i2cms_pkg, the block and i2c_master_byte_sequencer_checker.
module i2c_master_byte_sequencer_tb;

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [i2cms_pkg::REQ_DATA_BITS-1:0]   req_tdata  = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b1;
   logic [i2cms_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                                  rsp_tlast;
   int                                    fail_count;
   int                                    slots_pending;
   bit                                    calm       = 1'b0;  // no idling at the end
   int                                    cmds_sent  = 0;

   i2c_master_byte_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   i2c_master_byte_sequencer_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .slots_pending (slots_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Slot receiver back-pressure: stall bursts between calm stretches
   initial begin : slot_stalls
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   // One command transaction, with an optional gap in front
   task automatic send_cmd(logic [1:0] op, logic [7:0] wr_byte, logic [7:0] tgt);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, tgt, wr_byte, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmds_sent++;
   endtask

   task automatic send_noise();
      send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
   endtask

   // A well-formed bus transfer: start, address, data bytes, optional restart, stop
   task automatic send_transfer();
      int nbytes;
      send_cmd(i2cms_pkg::OP_START, 8'($urandom), 8'($urandom));
      send_cmd(i2cms_pkg::OP_WRITE, 8'($urandom), 8'($urandom));
      nbytes = $urandom_range(0, 4);
      for (int i = 0; i < nbytes; i++)
         send_cmd($urandom_range(0, 1) ? i2cms_pkg::OP_WRITE : i2cms_pkg::OP_READ,
                  8'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         send_cmd(i2cms_pkg::OP_START, 8'($urandom), 8'($urandom));
         send_cmd(i2cms_pkg::OP_WRITE, 8'($urandom), 8'($urandom));
         send_cmd(i2cms_pkg::OP_READ, 8'($urandom), 8'($urandom));
      end
      send_cmd(i2cms_pkg::OP_STOP, 8'($urandom), 8'($urandom));
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every command, byte extremes, repeated start and stop commands
      send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00);
      send_cmd(i2cms_pkg::OP_WRITE, 8'h00, 8'h00);
      send_cmd(i2cms_pkg::OP_WRITE, 8'hFF, 8'hFF);
      send_cmd(i2cms_pkg::OP_WRITE, 8'hA5, 8'h00);
      send_cmd(i2cms_pkg::OP_WRITE, 8'h80, 8'h00);
      send_cmd(i2cms_pkg::OP_WRITE, 8'h01, 8'h00);
      send_cmd(i2cms_pkg::OP_READ,  8'h00, 8'h00);
      send_cmd(i2cms_pkg::OP_READ,  8'hFF, 8'hFF);
      send_cmd(i2cms_pkg::OP_READ,  8'h00, 8'h5A);
      send_cmd(i2cms_pkg::OP_READ,  8'h00, 8'h80);
      send_cmd(i2cms_pkg::OP_READ,  8'h00, 8'h01);
      send_cmd(i2cms_pkg::OP_STOP,  8'h00, 8'h00);
      send_cmd(i2cms_pkg::OP_STOP,  8'hFF, 8'hFF);
      send_cmd(i2cms_pkg::OP_START, 8'hFF, 8'hFF);
      send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00);
      send_cmd(i2cms_pkg::OP_READ,  8'h00, 8'hC3);
      send_cmd(i2cms_pkg::OP_WRITE, 8'h3C, 8'hFF);
      send_cmd(i2cms_pkg::OP_STOP,  8'h00, 8'h00);

      // Random: mostly well-formed transfers, some loose commands
      while (cmds_sent < 245) begin
         if (cmds_sent > 205)
            calm = 1'b1;
         if ($urandom_range(0, 4) == 0)
            send_noise();
         else
            send_transfer();
      end
      req_tvalid <= 1'b0;

      // Drain the expected slots, then let the block settle
      @(posedge clock);
      while (slots_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (fail_count == 0 && slots_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
